@@ rtl/iwws_pkg.sv @@
`default_nettype none

package iwws_pkg;

  // Port values: bit 3 drives SDA, bit 2 drives SCL, all other bits high
  localparam logic [7:0] PORT_BOTH_HIGH = 8'hff;
  localparam logic [7:0] PORT_SDA_LOW   = 8'hf7;
  localparam logic [7:0] PORT_BOTH_LOW  = 8'hf3;
  localparam logic [7:0] PORT_SCL_LOW   = 8'hfb;

  // Counter widths and end values
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BITCNT_W = 4;
  localparam logic [PHASE_W-1:0]  PHASE_LAST_BIT  = 3'd4;
  localparam logic [PHASE_W-1:0]  PHASE_LAST_EDGE = 3'd2;
  localparam logic [BITCNT_W-1:0] BITCNT_ACK      = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BIT,
    ST_STOP
  } state_t;

  typedef enum logic [1:0] {
    SEG_START,
    SEG_BIT,
    SEG_STOP
  } segment_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     emit;
    segment_t segment;
    logic     final_phase;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic command_open;
    logic last_flag;
    logic phase_end;
    logic ack_slot;
    logic slot_free;
  } status_t;

  // Start condition: SDA falls while SCL is high
  function automatic logic [7:0] start_pattern(input logic [PHASE_W-1:0] phase);
    logic [7:0] v;
    unique case (phase)
      3'd0:    v = PORT_BOTH_HIGH;
      3'd1:    v = PORT_SDA_LOW;
      default: v = PORT_BOTH_LOW;
    endcase
    return v;
  endfunction

  // Stop condition: SDA rises while SCL is high
  function automatic logic [7:0] stop_pattern(input logic [PHASE_W-1:0] phase);
    logic [7:0] v;
    unique case (phase)
      3'd0:    v = PORT_BOTH_LOW;
      3'd1:    v = PORT_SDA_LOW;
      default: v = PORT_BOTH_HIGH;
    endcase
    return v;
  endfunction

  // Five-phase data bit
  function automatic logic [7:0] bit_pattern(input logic one,
                                             input logic [PHASE_W-1:0] phase);
    logic [7:0] v;
    unique case (phase)
      3'd1:    v = one ? PORT_SCL_LOW : PORT_BOTH_LOW;
      3'd2:    v = one ? PORT_BOTH_HIGH : PORT_SDA_LOW;
      3'd3:    v = one ? PORT_SCL_LOW : PORT_BOTH_LOW;
      default: v = PORT_BOTH_LOW;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/iwws_byte_if.sv @@
`default_nettype none

interface iwws_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_command;

  modport source (output valid, output data_byte, output last_of_command, input ready);
  modport sink   (input valid, input data_byte, input last_of_command, output ready);
endinterface

`default_nettype wire

@@ rtl/iwws_port_if.sv @@
`default_nettype none

interface iwws_port_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_value;
  logic       last;

  modport source (output valid, output port_value, output last, input ready);
  modport sink   (input valid, input port_value, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/iwws_ctrl.sv @@
`default_nettype none

module iwws_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_ready,
  input  wire iwws_pkg::status_t status,
  output iwws_pkg::cmd_t        cmd
);

  iwws_pkg::state_t state;
  iwws_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iwws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      iwws_pkg::ST_IDLE: begin
        if (byte_valid) begin
          state_next = status.command_open ? iwws_pkg::ST_BIT : iwws_pkg::ST_START;
        end
      end
      iwws_pkg::ST_START: begin
        if (status.slot_free && status.phase_end) begin
          state_next = iwws_pkg::ST_BIT;
        end
      end
      iwws_pkg::ST_BIT: begin
        if (status.slot_free && status.phase_end && status.ack_slot) begin
          state_next = status.last_flag ? iwws_pkg::ST_STOP : iwws_pkg::ST_IDLE;
        end
      end
      iwws_pkg::ST_STOP: begin
        if (status.slot_free && status.phase_end) begin
          state_next = iwws_pkg::ST_IDLE;
        end
      end
      default: state_next = iwws_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    byte_ready      = 1'b0;
    cmd.load        = 1'b0;
    cmd.emit        = 1'b0;
    cmd.segment     = iwws_pkg::SEG_BIT;
    cmd.final_phase = 1'b0;
    unique case (state)
      iwws_pkg::ST_IDLE: begin
        byte_ready = 1'b1;
        cmd.load   = byte_valid;
      end
      iwws_pkg::ST_START: begin
        cmd.emit    = status.slot_free;
        cmd.segment = iwws_pkg::SEG_START;
      end
      iwws_pkg::ST_BIT: begin
        cmd.emit        = status.slot_free;
        cmd.segment     = iwws_pkg::SEG_BIT;
        cmd.final_phase = status.phase_end && status.ack_slot && !status.last_flag;
      end
      iwws_pkg::ST_STOP: begin
        cmd.emit        = status.slot_free;
        cmd.segment     = iwws_pkg::SEG_STOP;
        cmd.final_phase = status.phase_end;
      end
      default: ;
    endcase
  end

  // Idle never drives the port
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    state == iwws_pkg::ST_IDLE |-> !cmd.emit)
    else $error("emit while idle");

  // The final phase of a byte returns to idle
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.final_phase |=> state == iwws_pkg::ST_IDLE)
    else $error("final phase did not return to idle");

  // A byte with a command open skips the start condition
  a_open_skips_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load && status.command_open |=> state == iwws_pkg::ST_BIT)
    else $error("start condition inside an open command");

endmodule

`default_nettype wire

@@ rtl/iwws_datapath.sv @@
`default_nettype none

module iwws_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_of_command,
  input  wire iwws_pkg::cmd_t    cmd,
  output iwws_pkg::status_t      status,
  output logic                   port_valid,
  input  wire logic              port_ready,
  output logic [7:0]             port_value,
  output logic                   port_last
);

  logic [7:0]                    shift;
  logic                          last_flag;
  logic                          command_open;
  logic [iwws_pkg::BITCNT_W-1:0] bit_cnt;
  logic [iwws_pkg::PHASE_W-1:0]  phase;
  logic                          phase_end;
  logic [7:0]                    pattern;

  // Phase end depends on the segment length
  always_comb begin
    if (cmd.segment == iwws_pkg::SEG_BIT) begin
      phase_end = (phase == iwws_pkg::PHASE_LAST_BIT);
    end else begin
      phase_end = (phase == iwws_pkg::PHASE_LAST_EDGE);
    end
  end

  // Select the port value for the current phase
  always_comb begin
    unique case (cmd.segment)
      iwws_pkg::SEG_START: pattern = iwws_pkg::start_pattern(phase);
      iwws_pkg::SEG_STOP:  pattern = iwws_pkg::stop_pattern(phase);
      default:             pattern = iwws_pkg::bit_pattern(shift[7], phase);
    endcase
  end

  assign status.command_open = command_open;
  assign status.last_flag    = last_flag;
  assign status.phase_end    = phase_end;
  assign status.ack_slot     = (bit_cnt == iwws_pkg::BITCNT_ACK);
  assign status.slot_free    = !port_valid || port_ready;

  // Hold the byte; zeros shift in, so the acknowledge slot sends a zero bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift     <= data_byte;
      last_flag <= last_of_command;
    end else if (cmd.emit && phase_end && cmd.segment == iwws_pkg::SEG_BIT) begin
      shift <= {shift[6:0], 1'b0};
    end
  end

  // Advance phase and bit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      command_open <= 1'b0;
      bit_cnt      <= '0;
      phase        <= '0;
    end else if (cmd.load) begin
      command_open <= !last_of_command;
      bit_cnt      <= '0;
      phase        <= '0;
    end else if (cmd.emit) begin
      if (phase_end) begin
        phase <= '0;
        if (cmd.segment == iwws_pkg::SEG_BIT) begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  // Output register: load on emit, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      port_valid <= 1'b0;
    end else if (cmd.emit) begin
      port_valid <= 1'b1;
    end else if (port_ready) begin
      port_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      port_value <= pattern;
      port_last  <= cmd.final_phase;
    end
  end

  // Never overwrite a value that has not been taken
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!port_valid || port_ready))
    else $error("output register overwritten");

  // All data bits have left by the acknowledge slot
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    bit_cnt == iwws_pkg::BITCNT_ACK |-> shift == 8'h00)
    else $error("acknowledge slot with data left");

  // Bit counter stays within nine slots
  a_bitcnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.segment == iwws_pkg::SEG_BIT |-> bit_cnt <= iwws_pkg::BITCNT_ACK)
    else $error("bit counter past acknowledge slot");

endmodule

`default_nettype wire

@@ rtl/i2c_write_waveform_sequencer_unit.sv @@
// I2C write waveform sequencer.
//
// byte_ch takes one byte of a write-only I2C command per transfer, with
// last_of_command marking the byte that ends the command. port_ch gives
// the port values that bit-bang that byte: bit 3 drives SDA, bit 2 drives
// SCL, the other bits stay high. The first byte of a command is preceded
// by a start condition (3 values), every byte gives eight data bits MSB
// first and a zero acknowledge bit (5 values each), and the last byte is
// followed by a stop condition (3 values). Each byte yields 45 to 51
// values; the final one carries last = 1.
// One byte is worked at a time. byte_ch.ready is high only while idle;
// after a byte transfer the controller leaves idle, then port_ch.valid
// rises once the output register has loaded the first value. While port_ch
// is not stalled, one value per cycle leaves the single output register.
// A stall on port_ch holds the output register and freezes the sequence.
// Synchronous reset closes any open command, drops port_ch.valid and
// returns to idle, so the next byte begins with a start condition.
`default_nettype none

module i2c_write_waveform_sequencer_unit (
  input  wire logic clk,
  input  wire logic rst,
  iwws_byte_if.sink byte_ch,
  iwws_port_if.source port_ch
);

  iwws_pkg::cmd_t    cmd;
  iwws_pkg::status_t status;

  iwws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_ch.valid),
    .byte_ready (byte_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  iwws_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .data_byte       (byte_ch.data_byte),
    .last_of_command (byte_ch.last_of_command),
    .cmd             (cmd),
    .status          (status),
    .port_valid      (port_ch.valid),
    .port_ready      (port_ch.ready),
    .port_value      (port_ch.port_value),
    .port_last       (port_ch.last)
  );

endmodule

`default_nettype wire
